// File: rtl/i8080_pkg.sv
// package for the 8080 instruction executor: item structs, codes, helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package i8080_pkg;
    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW = $clog2(MEM_DEPTH);

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_EXEC   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_HALTED = 2'd1;
    localparam logic [1:0] ST_UNIMP  = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    localparam logic [7:0] OPC_HLT = 8'h76;
    localparam logic [7:0] OPC_NOP = 8'h00;
    localparam logic [7:0] OPC_SHLD = 8'h22;
    localparam logic [7:0] OPC_LHLD = 8'h2A;
    localparam logic [7:0] OPC_STA = 8'h32;
    localparam logic [7:0] OPC_LDA = 8'h3A;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] address;
        logic [7:0]  data;
    } i8080_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pc_out;
        logic [15:0] sp_out;
        logic [7:0]  acc_out;
        logic [15:0] bc_out;
        logic [15:0] de_out;
        logic [15:0] hl_out;
        logic [4:0]  flags_out;
        logic [7:0]  read_data;
    } i8080_out_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MEMRD, S_FETCH, S_DECODE, S_OP1, S_OP2, S_DRD1, S_DRD2,
        S_EXEC, S_WR1, S_WR2, S_DONE
    } i8080_state_t;

    function automatic logic [4:0] zsp(input logic [4:0] f, input logic [7:0] v);
        zsp = {v == 8'd0, v[7], ~^v, f[1], f[0]};
    endfunction
endpackage
`default_nettype wire

// File: rtl/i8080_ram.sv
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module i8080_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: rtl/i8080_instruction_executor_core.sv
// 8080 instruction executor top level: sequencer, register file, alu
// depends on i8080_pkg and i8080_ram
// steps: write and read items access memory once; unused ops and execute while halted
// go straight to the result; instructions fetch, then take up to two operand bytes,
// up to two data reads and up to two writes over one memory port
// throughput: one item at a time; s_ready is low while an item is in work and until
// its result is taken
// reset: synchronous active low, clears registers, flags, halt and the sequencer;
// memory content is undefined until written
`timescale 1ns / 1ps
`default_nettype none
module i8080_instruction_executor_core
    import i8080_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire i8080_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output i8080_out_t      m_data
);
    i8080_state_t state_reg, state_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  b_reg, b_next, c_reg, c_next, d_reg, d_next, e_reg, e_next;
    logic [7:0]  h_reg, h_next, l_reg, l_next;
    logic [15:0] sp_reg, sp_next, pc_reg, pc_next;
    logic [4:0]  f_reg, f_next;
    logic        halt_reg, halt_next;
    i8080_in_t   in_reg, in_next;
    logic [7:0]  opc_reg, opc_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [7:0]  d1_reg, d1_next, d2_reg, d2_next;
    logic [15:0] wpc_reg, wpc_next;
    logic [15:0] wa_reg, wa_next;
    logic [7:0]  wd1_reg, wd1_next, wd2_reg, wd2_next;
    logic [1:0]  nwr_reg, nwr_next;
    logic [1:0]  st_reg, st_next;
    logic        mv_reg, mv_next;
    i8080_out_t  out_reg, out_next;

    logic                we;
    logic [15:0]         maddr;
    logic [7:0]          wdata, rdata;

    i8080_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .addr(maddr[MEM_AW-1:0]), .wdata(wdata), .rdata(rdata)
    );

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    function automatic logic inrange(input logic [15:0] x);
        inrange = ({1'b0, x} < 17'(MEM_DEPTH));
    endfunction

    // decode helpers
    logic [2:0] dst, src;
    logic [1:0] rp;
    logic [15:0] hl, imm, rpv;
    logic       m_src;
    assign dst = opc_reg[5:3];
    assign src = opc_reg[2:0];
    assign rp  = opc_reg[5:4];
    assign hl  = {h_reg, l_reg};
    assign imm = {hi_reg, lo_reg};
    always_comb begin
        case (rp)
            2'd0: rpv = {b_reg, c_reg};
            2'd1: rpv = {d_reg, e_reg};
            2'd2: rpv = hl;
            default: rpv = sp_reg;
        endcase
    end

    function automatic logic [7:0] getr(input logic [2:0] code, input logic [7:0] b,
        input logic [7:0] c, input logic [7:0] d, input logic [7:0] e, input logic [7:0] h,
        input logic [7:0] l, input logic [7:0] m, input logic [7:0] a);
        case (code)
            3'd0: getr = b; 3'd1: getr = c; 3'd2: getr = d; 3'd3: getr = e;
            3'd4: getr = h; 3'd5: getr = l; 3'd6: getr = m; default: getr = a;
        endcase
    endfunction

    // instruction class: operand bytes and unimplemented opcodes
    logic [1:0] n_ops;
    logic       unimp;
    always_comb begin
        n_ops = 2'd0;
        unimp = 1'b0;
        if (opc_reg >= 8'hC0) begin
            unimp = 1'b1;
        end else if (opc_reg < 8'h40) begin
            case (src)
                3'd0: unimp = (opc_reg != OPC_NOP);
                3'd1: n_ops = opc_reg[3] ? 2'd0 : 2'd2;
                3'd2: n_ops = rp[1] ? 2'd2 : 2'd0;
                3'd6: n_ops = 2'd1;
                default: n_ops = 2'd0;
            endcase
        end
    end
    assign m_src = (opc_reg >= 8'h40) && (src == 3'd6) && (opc_reg != OPC_HLT);

    // first and second data reads and the first read address
    logic       rd1, rd2;
    logic [15:0] ra1;
    always_comb begin
        rd1 = 1'b0; rd2 = 1'b0; ra1 = hl;
        if (opc_reg >= 8'h40 && m_src) rd1 = 1'b1;
        else if (opc_reg < 8'h40 && (src == 3'd4 || src == 3'd5) && dst == 3'd6) rd1 = 1'b1;
        else if (opc_reg < 8'h40 && src == 3'd2 && opc_reg[3]) begin
            rd1 = 1'b1;
            ra1 = rp[1] ? imm : rpv;
            rd2 = (opc_reg == OPC_LHLD);
        end
    end

    // shared alu
    logic [7:0] alu_v, alu_res;
    logic [4:0] alu_f;
    logic [8:0] sum;
    logic [4:0] hsum;
    logic       cin;
    logic [7:0] nv;
    always_comb begin
        alu_v = getr(src, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, d1_reg, a_reg);
        nv = (dst == 3'd2 || dst == 3'd3 || dst == 3'd7) ? ~alu_v : alu_v;
        case (dst)
            3'd1: cin = f_reg[1];
            3'd2, 3'd7: cin = 1'b1;
            3'd3: cin = ~f_reg[1];
            default: cin = 1'b0;
        endcase
        sum  = {1'b0, a_reg} + {1'b0, nv} + {8'd0, cin};
        hsum = {1'b0, a_reg[3:0]} + {1'b0, nv[3:0]} + {4'd0, cin};
        alu_f = f_reg;
        case (dst)
            3'd0, 3'd1: begin
                alu_res = sum[7:0]; alu_f[1] = sum[8]; alu_f[0] = hsum[4];
            end
            3'd2, 3'd3, 3'd7: begin
                alu_res = sum[7:0]; alu_f[1] = ~sum[8]; alu_f[0] = hsum[4];
            end
            3'd4: begin
                alu_res = a_reg & alu_v; alu_f[1] = 1'b0; alu_f[0] = a_reg[3] | alu_v[3];
            end
            3'd5: begin
                alu_res = a_reg ^ alu_v; alu_f[1] = 1'b0; alu_f[0] = 1'b0;
            end
            default: begin
                alu_res = a_reg | alu_v; alu_f[1] = 1'b0; alu_f[0] = 1'b0;
            end
        endcase
        alu_f = zsp(alu_f, alu_res);
    end

    // daa
    logic [7:0] daa_add, daa_res;
    logic       daa_cy;
    logic [4:0] daa_lo;
    always_comb begin
        daa_add = 8'd0;
        daa_cy = f_reg[1];
        if (a_reg[3:0] > 4'd9 || f_reg[0]) daa_add[3:0] = 4'd6;
        if (a_reg[7:4] > 4'd9 || f_reg[1] || (a_reg[7:4] >= 4'd9 && a_reg[3:0] > 4'd9)) begin
            daa_add[7:4] = 4'd6;
            daa_cy = 1'b1;
        end
        daa_lo  = {1'b0, a_reg[3:0]} + {1'b0, daa_add[3:0]};
        daa_res = a_reg + daa_add;
    end

    logic [16:0] dad;
    assign dad = {1'b0, hl} + {1'b0, rpv};

    always_comb begin
        logic [7:0] v;
        logic [2:0] sc;
        state_next = state_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        e_next = e_reg; h_next = h_reg; l_next = l_reg;
        sp_next = sp_reg; pc_next = pc_reg; f_next = f_reg; halt_next = halt_reg;
        in_next = in_reg; opc_next = opc_reg; lo_next = lo_reg; hi_next = hi_reg;
        d1_next = d1_reg; d2_next = d2_reg; wpc_next = wpc_reg;
        wa_next = wa_reg; wd1_next = wd1_reg; wd2_next = wd2_reg; nwr_next = nwr_reg;
        st_next = st_reg; mv_next = mv_reg; out_next = out_reg;
        we = 1'b0; maddr = wpc_reg; wdata = in_reg.data;
        v = 8'd0; sc = 3'd0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    in_next = s_data;
                    st_next = halt_reg ? ST_HALTED : ST_OK;
                    wpc_next = pc_reg;
                    if (s_data.op == OP_EXEC) begin
                        state_next = halt_reg ? S_DONE : S_FETCH;
                    end else if (s_data.op == OP_WRITE || s_data.op == OP_READ) begin
                        state_next = S_MEMRD;
                    end else begin
                        state_next = S_DONE;
                    end
                    d1_next = 8'd0;
                end
            end
            S_MEMRD: begin
                maddr = in_reg.address;
                if (!inrange(in_reg.address)) begin
                    st_next = ST_RANGE;
                    state_next = S_DONE;
                end else if (in_reg.op == OP_WRITE) begin
                    we = 1'b1;
                    state_next = S_DONE;
                end else begin
                    // read data comes from the ram register and is taken in S_DECODE
                    state_next = S_DECODE;
                end
            end
            S_FETCH: begin
                maddr = wpc_reg;
                if (!inrange(wpc_reg)) begin
                    st_next = ST_RANGE; state_next = S_DONE;
                end else begin
                    wpc_next = wpc_reg + 16'd1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (in_reg.op == OP_READ) begin
                    // memory read item: latch byte
                    d1_next = rdata;
                    state_next = S_DONE;
                end else begin
                    opc_next = rdata;
                    state_next = S_OP1;
                end
            end
            S_OP1: begin
                // issue first operand fetch or first data read, if any
                if (unimp) begin
                    st_next = ST_UNIMP; state_next = S_DONE;
                end else if (opc_reg == OPC_HLT) begin
                    state_next = S_EXEC;
                end else if (n_ops != 2'd0) begin
                    maddr = wpc_reg;
                    if (!inrange(wpc_reg)) begin
                        st_next = ST_RANGE; state_next = S_DONE;
                    end else begin
                        wpc_next = wpc_reg + 16'd1;
                        state_next = S_OP2;
                    end
                end else if (rd1) begin
                    maddr = ra1;
                    if (!inrange(ra1)) begin
                        st_next = ST_RANGE; state_next = S_DONE;
                    end else begin
                        state_next = S_DRD1;
                    end
                end else begin
                    state_next = S_EXEC;
                end
                nwr_next = 2'd0;
            end
            S_OP2: begin
                // rdata holds an operand byte; lo then hi
                if (nwr_reg == 2'd0) begin
                    lo_next = rdata;
                    if (n_ops == 2'd2) begin
                        maddr = wpc_reg;
                        nwr_next = 2'd1;
                        if (!inrange(wpc_reg)) begin
                            st_next = ST_RANGE; state_next = S_DONE;
                        end else begin
                            wpc_next = wpc_reg + 16'd1;
                        end
                    end else begin
                        state_next = S_EXEC;
                    end
                end else begin
                    hi_next = rdata;
                    nwr_next = 2'd0;
                    if (rd1) begin
                        maddr = {rdata, lo_reg};
                        if (!inrange({rdata, lo_reg})) begin
                            st_next = ST_RANGE; state_next = S_DONE;
                        end else begin
                            state_next = S_DRD1;
                        end
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_DRD1: begin
                d1_next = rdata;
                if (rd2) begin
                    maddr = imm + 16'd1;
                    if (!inrange(imm + 16'd1)) begin
                        st_next = ST_RANGE; state_next = S_DONE;
                    end else begin
                        state_next = S_DRD2;
                    end
                end else begin
                    state_next = S_EXEC;
                end
            end
            S_DRD2: begin
                d2_next = rdata;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_DONE;
                wa_next = hl;
                nwr_next = 2'd0;
                pc_next = wpc_reg;
                if (opc_reg == OPC_HLT) begin
                    halt_next = 1'b1; st_next = ST_HALTED;
                end else if (opc_reg >= 8'h80) begin
                    f_next = alu_f;
                    if (dst != 3'd7) a_next = alu_res;
                end else if (opc_reg >= 8'h40) begin
                    v = alu_v;
                    case (dst)
                        3'd0: b_next = v; 3'd1: c_next = v; 3'd2: d_next = v;
                        3'd3: e_next = v; 3'd4: h_next = v; 3'd5: l_next = v;
                        3'd6: begin wd1_next = v; nwr_next = 2'd1; end
                        default: a_next = v;
                    endcase
                end else begin
                    sc = src;
                    case (sc)
                        3'd1: begin
                            if (opc_reg[3]) begin
                                h_next = dad[15:8]; l_next = dad[7:0]; f_next[1] = dad[16];
                            end else begin
                                case (rp)
                                    2'd0: begin b_next = hi_reg; c_next = lo_reg; end
                                    2'd1: begin d_next = hi_reg; e_next = lo_reg; end
                                    2'd2: begin h_next = hi_reg; l_next = lo_reg; end
                                    default: sp_next = imm;
                                endcase
                            end
                        end
                        3'd2: begin
                            if (opc_reg[3]) begin
                                if (opc_reg == OPC_LHLD) begin
                                    l_next = d1_reg; h_next = d2_reg;
                                end else begin
                                    a_next = d1_reg;
                                end
                            end else if (opc_reg == OPC_SHLD) begin
                                wa_next = imm; wd1_next = l_reg; wd2_next = h_reg;
                                nwr_next = 2'd2;
                            end else begin
                                wa_next = (opc_reg == OPC_STA) ? imm : rpv;
                                wd1_next = a_reg; nwr_next = 2'd1;
                            end
                        end
                        3'd3: begin
                            logic [15:0] np;
                            np = opc_reg[3] ? rpv - 16'd1 : rpv + 16'd1;
                            case (rp)
                                2'd0: begin b_next = np[15:8]; c_next = np[7:0]; end
                                2'd1: begin d_next = np[15:8]; e_next = np[7:0]; end
                                2'd2: begin h_next = np[15:8]; l_next = np[7:0]; end
                                default: sp_next = np;
                            endcase
                        end
                        3'd4, 3'd5, 3'd6: begin
                            v = getr(dst, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, d1_reg,
                                a_reg);
                            if (sc == 3'd4) begin
                                v = v + 8'd1; f_next[0] = (v[3:0] == 4'd0);
                                f_next = zsp(f_next, v);
                            end else if (sc == 3'd5) begin
                                v = v - 8'd1; f_next[0] = (v[3:0] != 4'hF);
                                f_next = zsp(f_next, v);
                            end else begin
                                v = lo_reg;
                            end
                            case (dst)
                                3'd0: b_next = v; 3'd1: c_next = v; 3'd2: d_next = v;
                                3'd3: e_next = v; 3'd4: h_next = v; 3'd5: l_next = v;
                                3'd6: begin wd1_next = v; nwr_next = 2'd1; end
                                default: a_next = v;
                            endcase
                        end
                        3'd7: begin
                            case (dst)
                                3'd0: begin a_next = {a_reg[6:0], a_reg[7]}; f_next[1] = a_reg[7]; end
                                3'd1: begin a_next = {a_reg[0], a_reg[7:1]}; f_next[1] = a_reg[0]; end
                                3'd2: begin a_next = {a_reg[6:0], f_reg[1]}; f_next[1] = a_reg[7]; end
                                3'd3: begin a_next = {f_reg[1], a_reg[7:1]}; f_next[1] = a_reg[0]; end
                                3'd4: begin
                                    a_next = daa_res;
                                    f_next = zsp({f_reg[4:2], daa_cy, daa_lo[4]}, daa_res);
                                end
                                3'd5: a_next = ~a_reg;
                                3'd6: f_next[1] = 1'b1;
                                default: f_next[1] = ~f_reg[1];
                            endcase
                        end
                        default: ;
                    endcase
                end
                // a write out of range drops the whole instruction
                if (nwr_next != 2'd0 && (!inrange(wa_next) ||
                    (nwr_next == 2'd2 && !inrange(wa_next + 16'd1)))) begin
                    st_next = ST_RANGE;
                    a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
                    e_next = e_reg; h_next = h_reg; l_next = l_reg;
                    sp_next = sp_reg; pc_next = pc_reg; f_next = f_reg; halt_next = halt_reg;
                    nwr_next = 2'd0;
                end else if (nwr_next != 2'd0) begin
                    state_next = S_WR1;
                end
            end
            S_WR1: begin
                we = 1'b1; maddr = wa_reg; wdata = wd1_reg;
                state_next = (nwr_reg == 2'd2) ? S_WR2 : S_DONE;
            end
            S_WR2: begin
                we = 1'b1; maddr = wa_reg + 16'd1; wdata = wd2_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mv_reg) begin
                    out_next.status = st_reg;
                    out_next.pc_out = pc_reg;
                    out_next.sp_out = sp_reg;
                    out_next.acc_out = a_reg;
                    out_next.bc_out = {b_reg, c_reg};
                    out_next.de_out = {d_reg, e_reg};
                    out_next.hl_out = hl;
                    out_next.flags_out = f_reg;
                    out_next.read_data = (in_reg.op == OP_READ && st_reg != ST_RANGE) ?
                        d1_reg : 8'd0;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
            e_reg <= '0; h_reg <= '0; l_reg <= '0;
            sp_reg <= '0; pc_reg <= '0; f_reg <= '0; halt_reg <= 1'b0;
            mv_reg <= 1'b0; nwr_reg <= '0; st_reg <= '0;
        end else begin
            state_reg <= state_next;
            a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
            e_reg <= e_next; h_reg <= h_next; l_reg <= l_next;
            sp_reg <= sp_next; pc_reg <= pc_next; f_reg <= f_next; halt_reg <= halt_next;
            mv_reg <= mv_next; nwr_reg <= nwr_next; st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg <= in_next; opc_reg <= opc_next; lo_reg <= lo_next; hi_reg <= hi_next;
        d1_reg <= d1_next; d2_reg <= d2_next; wpc_reg <= wpc_next;
        wa_reg <= wa_next; wd1_reg <= wd1_next; wd2_reg <= wd2_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("accept while busy");
    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(halt_reg) |-> halt_reg) else $error("halt cleared");
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !we) else $error("memory write while idle");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data))) else $error("result lost");
`endif
endmodule
`default_nettype wire
